// ----- hw/rtl/hbfp_pkg.sv -----
// hbfp_pkg: shared widths, constants and beat structs for the heat budget fire permit
// depends on nothing; used by hbfp_step and heat_budget_fire_permit
`timescale 1ns / 1ps

package hbfp_pkg;

  localparam int ANGLE_W  = 32;
  localparam int REPORT_W = 16;
  localparam int HEAT_W   = 24;
  localparam int LAG_W    = 8;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_COOL_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COOL_RATE  = 1'b1;

  // heat is kept in units of 1/200
  localparam logic [HEAT_W-1:0] HEAT_MAX      = 24'd16777215;
  localparam logic [HEAT_W-1:0] HEAT_SCALE    = 24'd200;
  localparam logic [HEAT_W-1:0] SHOT_HEAT     = 24'd2000;
  localparam logic [HEAT_W-1:0] RESYNC_MARGIN = 24'd4000;
  localparam logic [HEAT_W:0]   LIMIT_MARGIN  = 25'd6000;
  localparam logic [LAG_W-1:0]  LAG_TICKS_MAX = 8'd200;
  localparam logic signed [ANGLE_W+1:0] SHOT_STEP = 34'sd40;

  localparam logic [CFG_W-1:0] DEFAULT_LIMIT = 16'd3000;
  localparam logic [CFG_W-1:0] DEFAULT_RATE  = 16'd20;

  // one input beat
  typedef struct packed {
    logic signed [ANGLE_W-1:0] feeder_angle;
    logic [REPORT_W-1:0]       reported_heat;
    logic                      clear_reference;
  } step_in_t;

  // one result beat
  typedef struct packed {
    logic              fire_permitted;
    logic              shot_counted;
    logic [HEAT_W-1:0] heat_estimate;
  } step_out_t;

endpackage

// ----- hw/rtl/heat_budget_fire_permit.sv -----
// heat_budget_fire_permit: leaky-bucket heat limiter that gates firing per tick
// path: input and result registers; a result beat is offered once its input beat has been
// accepted and has moved on from the input register into the result register
// throughput: one beat per cycle unless out_stall holds a result, set by the hbfp_step update
// reset: synchronous active-low rst_n clears heat, reference angle, lag count,
// both configuration registers and all valid flags; no clearing pass is needed
// depends on hbfp_pkg and hbfp_step
`timescale 1ns / 1ps

module heat_budget_fire_permit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [hbfp_pkg::ANGLE_W-1:0]  in_feeder_angle,
  input  logic [hbfp_pkg::REPORT_W-1:0]        in_reported_heat,
  input  logic                                 in_clear_reference,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_fire_permitted,
  output logic                                 out_shot_counted,
  output logic [hbfp_pkg::HEAT_W-1:0]          out_heat_estimate,
  // configuration port
  input  logic                                 cfg_wr_en,
  input  logic [hbfp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hbfp_pkg::CFG_W-1:0]           cfg_wdata
);

  logic [hbfp_pkg::CFG_W-1:0] cool_limit_r;
  logic [hbfp_pkg::CFG_W-1:0] cool_rate_r;
  logic [hbfp_pkg::CFG_W-1:0] limit_eff;
  logic [hbfp_pkg::CFG_W-1:0] rate_eff;

  logic                 in_vld_r;
  hbfp_pkg::step_in_t   in_beat_r;
  logic                 out_vld_r;
  hbfp_pkg::step_out_t  out_beat_r;
  hbfp_pkg::step_out_t  step_result;

  logic out_free;
  logic step_go;
  logic in_take;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cool_limit_r <= '0;
      cool_rate_r  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        hbfp_pkg::CFG_COOL_LIMIT: cool_limit_r <= cfg_wdata;
        hbfp_pkg::CFG_COOL_RATE:  cool_rate_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // zero limit selects the default limit and rate
  assign limit_eff = (cool_limit_r == '0) ? hbfp_pkg::DEFAULT_LIMIT : cool_limit_r;
  assign rate_eff  = (cool_limit_r == '0) ? hbfp_pkg::DEFAULT_RATE  : cool_rate_r;

  // pipeline flow control
  assign out_free = ~out_vld_r | ~out_stall;
  assign step_go  = in_vld_r & out_free;
  assign in_stall = in_vld_r & ~out_free;
  assign in_take  = in_valid & ~in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (~in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_beat_r.feeder_angle    <= in_feeder_angle;
      in_beat_r.reported_heat   <= in_reported_heat;
      in_beat_r.clear_reference <= in_clear_reference;
    end
  end

  // tick state and update logic
  hbfp_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_go),
    .item    (in_beat_r),
    .limit   (limit_eff),
    .rate    (rate_eff),
    .result  (step_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      out_beat_r <= step_result;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_fire_permitted = out_beat_r.fire_permitted;
  assign out_shot_counted   = out_beat_r.shot_counted;
  assign out_heat_estimate  = out_beat_r.heat_estimate;

endmodule

// ----- hw/rtl/hbfp_step.sv -----
// hbfp_step: tick state (heat, reference angle, lag count) and its update logic
// depends on hbfp_pkg
`timescale 1ns / 1ps

module hbfp_step (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step_en,
  input  hbfp_pkg::step_in_t              item,
  input  logic [hbfp_pkg::CFG_W-1:0]      limit,
  input  logic [hbfp_pkg::CFG_W-1:0]      rate,
  output hbfp_pkg::step_out_t             result
);

  logic [hbfp_pkg::HEAT_W-1:0]          heat_r, heat_nxt;
  logic signed [hbfp_pkg::ANGLE_W-1:0]  ref_r, ref_nxt;
  logic [hbfp_pkg::LAG_W-1:0]           lag_r, lag_nxt;

  logic signed [hbfp_pkg::ANGLE_W-1:0]  ref_base;
  logic signed [hbfp_pkg::ANGLE_W+1:0]  ref_plus;
  logic signed [hbfp_pkg::ANGLE_W+1:0]  angle_ext;
  logic                                 shot;
  logic [hbfp_pkg::HEAT_W:0]            heat_add;
  logic [hbfp_pkg::HEAT_W-1:0]          heat_sat;
  logic [hbfp_pkg::HEAT_W-1:0]          rate_ext;
  logic [hbfp_pkg::HEAT_W-1:0]          heat_cool;
  logic [hbfp_pkg::HEAT_W-1:0]          report_scaled;
  logic [hbfp_pkg::HEAT_W-1:0]          report_margin;
  logic [hbfp_pkg::HEAT_W-1:0]          heat_sync;
  logic [hbfp_pkg::LAG_W-1:0]           lag_inc;
  logic [hbfp_pkg::HEAT_W-1:0]          limit_scaled;
  logic                                 over_limit;

  // shot detection against the reference angle, compared without wrap
  always_comb begin
    ref_base  = item.clear_reference ? '0 : ref_r;
    ref_plus  = {{2{ref_base[hbfp_pkg::ANGLE_W-1]}}, ref_base} + hbfp_pkg::SHOT_STEP;
    angle_ext = {{2{item.feeder_angle[hbfp_pkg::ANGLE_W-1]}}, item.feeder_angle};
    shot      = angle_ext > ref_plus;
    ref_nxt   = shot ? item.feeder_angle : ref_base;
  end

  // shot heat with saturation, then cooling clamped at zero
  always_comb begin
    heat_add = {1'b0, heat_r} + (shot ? {1'b0, hbfp_pkg::SHOT_HEAT} : '0);
    heat_sat = heat_add[hbfp_pkg::HEAT_W] ? hbfp_pkg::HEAT_MAX
                                          : heat_add[hbfp_pkg::HEAT_W-1:0];
    rate_ext = {{(hbfp_pkg::HEAT_W-hbfp_pkg::CFG_W){1'b0}}, rate};
    heat_cool = (heat_sat > rate_ext) ? heat_sat - rate_ext : '0;
  end

  // resync to the reported heat and track how long the estimate lags above it
  always_comb begin
    report_scaled = {{(hbfp_pkg::HEAT_W-hbfp_pkg::REPORT_W){1'b0}}, item.reported_heat}
                    * hbfp_pkg::HEAT_SCALE;
    report_margin = report_scaled + hbfp_pkg::RESYNC_MARGIN;
    heat_sync     = (report_scaled > heat_cool) ? report_margin : heat_cool;
    lag_inc       = (report_margin < heat_sync) ? lag_r + 1'b1 : '0;
    if (lag_inc > hbfp_pkg::LAG_TICKS_MAX) begin
      heat_nxt = report_scaled;
      lag_nxt  = '0;
    end else begin
      heat_nxt = heat_sync;
      lag_nxt  = lag_inc;
    end
  end

  // permit unless heat exceeds limit - 30, compared as heat + 30 > limit
  always_comb begin
    limit_scaled = {{(hbfp_pkg::HEAT_W-hbfp_pkg::CFG_W){1'b0}}, limit} * hbfp_pkg::HEAT_SCALE;
    over_limit   = ({1'b0, heat_nxt} + hbfp_pkg::LIMIT_MARGIN) > {1'b0, limit_scaled};
    result.fire_permitted = ~over_limit;
    result.shot_counted   = shot;
    result.heat_estimate  = heat_nxt;
  end

  // state update once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heat_r <= '0;
      ref_r  <= '0;
      lag_r  <= '0;
    end else if (step_en) begin
      heat_r <= heat_nxt;
      ref_r  <= ref_nxt;
      lag_r  <= lag_nxt;
    end
  end

endmodule

// ----- sim/tb_top.sv -----
// tb_top: self-checking bench for heat_budget_fire_permit, with its own tick-by-tick heat predictor
// depends on hbfp_pkg and the heat_budget_fire_permit rtl; needs no files or arguments
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned LONG_HOLD = 120;

  typedef logic [hbfp_pkg::REPORT_W-1:0] report_t;
  typedef logic [hbfp_pkg::CFG_W-1:0]    cfg_word_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                                in_valid;
  logic                                in_stall;
  logic signed [hbfp_pkg::ANGLE_W-1:0] in_feeder_angle;
  logic [hbfp_pkg::REPORT_W-1:0]       in_reported_heat;
  logic                                in_clear_reference;
  logic                                out_valid;
  logic                                out_stall;
  logic                                out_fire_permitted;
  logic                                out_shot_counted;
  logic [hbfp_pkg::HEAT_W-1:0]         out_heat_estimate;
  logic                                cfg_wr_en;
  logic [hbfp_pkg::CFG_IDX_W-1:0]      cfg_index;
  logic [hbfp_pkg::CFG_W-1:0]          cfg_wdata;

  heat_budget_fire_permit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_feeder_angle    (in_feeder_angle),
    .in_reported_heat   (in_reported_heat),
    .in_clear_reference (in_clear_reference),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_fire_permitted (out_fire_permitted),
    .out_shot_counted   (out_shot_counted),
    .out_heat_estimate  (out_heat_estimate),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always #6 clk = ~clk;

  // directed stimulus row: optional register update, one beat, optional fixed result
  typedef struct {
    bit                          do_cfg;
    logic [hbfp_pkg::CFG_W-1:0]  lim;
    logic [hbfp_pkg::CFG_W-1:0]  rate;
    hbfp_pkg::step_in_t          beat;
    bit                          typed;
    hbfp_pkg::step_out_t         want;
  } plan_row_t;

  plan_row_t plan[$];
  hbfp_pkg::step_out_t tick_results_due[$];
  int unsigned mismatches = 0;
  int unsigned beats_sent = 0;
  int unsigned eager_left = 0;
  int unsigned calm_left = 0;
  bit hold_req = 1'b0;
  logic signed [hbfp_pkg::ANGLE_W-1:0] wheel = '0;

  // predictor copy of the block's registers and state
  logic [hbfp_pkg::CFG_W-1:0]          limit_reg = '0;
  logic [hbfp_pkg::CFG_W-1:0]          rate_reg = '0;
  logic [hbfp_pkg::HEAT_W-1:0]         heat_est = '0;
  logic signed [hbfp_pkg::ANGLE_W-1:0] ref_angle = '0;
  logic [hbfp_pkg::LAG_W-1:0]          lag_count = '0;

  // one tick of the heat bucket: shot detect, cooling, resync, permit
  function automatic hbfp_pkg::step_out_t heat_tick(input hbfp_pkg::step_in_t b);
    logic [hbfp_pkg::CFG_W-1:0] lim;
    logic [hbfp_pkg::CFG_W-1:0] rate;
    logic [hbfp_pkg::HEAT_W:0]  heat;
    logic [hbfp_pkg::HEAT_W:0]  rep;
    logic                       shot;
    hbfp_pkg::step_out_t        r;
    lim = limit_reg;
    rate = rate_reg;
    if (lim == '0) begin
      lim = hbfp_pkg::DEFAULT_LIMIT;
      rate = hbfp_pkg::DEFAULT_RATE;
    end
    if (b.clear_reference) ref_angle = '0;
    // compare without wrap so a reference near the top never fires
    shot = longint'($signed(b.feeder_angle)) >
           longint'(ref_angle) + longint'(hbfp_pkg::SHOT_STEP);
    if (shot) ref_angle = b.feeder_angle;
    heat = {1'b0, heat_est};
    if (shot) begin
      heat = heat + hbfp_pkg::SHOT_HEAT;
      if (heat > {1'b0, hbfp_pkg::HEAT_MAX}) heat = {1'b0, hbfp_pkg::HEAT_MAX};
    end
    if (heat > rate) heat = heat - rate;
    else heat = '0;
    rep = '0;
    rep[hbfp_pkg::REPORT_W-1:0] = b.reported_heat;
    rep = rep * hbfp_pkg::HEAT_SCALE;
    if (rep > heat) heat = rep + hbfp_pkg::RESYNC_MARGIN;
    if (rep + hbfp_pkg::RESYNC_MARGIN < heat) lag_count = lag_count + 1'b1;
    else lag_count = '0;
    // lagging too long: snap to the report
    if (lag_count > hbfp_pkg::LAG_TICKS_MAX) begin
      heat = rep;
      lag_count = '0;
    end
    heat_est = heat[hbfp_pkg::HEAT_W-1:0];
    r.fire_permitted = !(longint'(heat_est) >
                         longint'(lim) * longint'(hbfp_pkg::HEAT_SCALE) -
                         longint'(hbfp_pkg::LIMIT_MARGIN));
    r.shot_counted = shot;
    r.heat_estimate = heat_est;
    return r;
  endfunction

  function automatic plan_row_t mk(input bit do_cfg, input logic [hbfp_pkg::CFG_W-1:0] lim,
                                   input logic [hbfp_pkg::CFG_W-1:0] rate,
                                   input logic [hbfp_pkg::ANGLE_W-1:0] ang,
                                   input logic [hbfp_pkg::REPORT_W-1:0] rep, input bit clr,
                                   input bit typed, input bit permit, input bit shot,
                                   input logic [hbfp_pkg::HEAT_W-1:0] heat);
    plan_row_t p;
    p.do_cfg = do_cfg;
    p.lim = lim;
    p.rate = rate;
    p.beat.feeder_angle = ang;
    p.beat.reported_heat = rep;
    p.beat.clear_reference = clr;
    p.typed = typed;
    p.want.fire_permitted = permit;
    p.want.shot_counted = shot;
    p.want.heat_estimate = heat;
    return p;
  endfunction

  // idle length: mostly none or short, a few long
  function automatic int unsigned idle_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // offer one beat, wait for it to be taken, then log its expected result
  task automatic send_tick(input hbfp_pkg::step_in_t b, input bit typed,
                           input hbfp_pkg::step_out_t want);
    int unsigned g;
    hbfp_pkg::step_out_t pred;
    if (eager_left != 0) begin
      eager_left--;
      g = 0;
    end else if (calm_left != 0) begin
      calm_left--;
      g = 0;
    end else begin
      g = idle_len();
      if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(30, 100);
    end
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_feeder_angle <= b.feeder_angle;
    in_reported_heat <= b.reported_heat;
    in_clear_reference <= b.clear_reference;
    do @(posedge clk); while (in_stall);
    pred = heat_tick(b);
    tick_results_due.push_back(typed ? want : pred);
    beats_sent++;
  endtask

  // hold the input side until every expected beat is back
  task automatic settle_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (tick_results_due.size() != 0);
  endtask

  // both registers back to back, only while idle
  task automatic write_regs(input logic [hbfp_pkg::CFG_W-1:0] lim,
                            input logic [hbfp_pkg::CFG_W-1:0] rate);
    cfg_wr_en <= 1'b1;
    cfg_index <= hbfp_pkg::CFG_COOL_LIMIT;
    cfg_wdata <= lim;
    @(posedge clk);
    cfg_index <= hbfp_pkg::CFG_COOL_RATE;
    cfg_wdata <= rate;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limit_reg = lim;
    rate_reg = rate;
  endtask

  // random traffic: firing bursts, lag runs, range edges, noise, pauses
  task automatic run_phase(input int unsigned count);
    int unsigned stop_at;
    int unsigned kind;
    int unsigned hi;
    int unsigned est;
    int unsigned jit;
    hbfp_pkg::step_in_t b;
    stop_at = beats_sent + count;
    while (beats_sent < stop_at) begin
      kind = $urandom_range(0, 9);
      if (kind <= 4) begin
        // feeder advancing, report tracking the estimate
        repeat ($urandom_range(5, 30)) begin
          wheel = wheel + $urandom_range(0, 90);
          b.feeder_angle = wheel;
          b.clear_reference = ($urandom_range(0, 29) == 0);
          if ($urandom_range(0, 7) == 0) begin
            b.reported_heat = report_t'($urandom_range(0, 4000));
          end else begin
            est = 32'(heat_est / hbfp_pkg::HEAT_SCALE);
            if (est > 65535) est = 65535;
            jit = $urandom_range(0, 40);
            b.reported_heat = (est > jit) ? report_t'(est - jit) : '0;
          end
          send_tick(b, 1'b0, '0);
        end
      end else if (kind <= 6) begin
        // high report, then a long low stretch to run out the lag counter
        hi = $urandom_range(2000, 65535);
        b.feeder_angle = wheel;
        b.clear_reference = 1'b0;
        b.reported_heat = report_t'(hi);
        send_tick(b, 1'b0, '0);
        repeat ($urandom_range(195, 215)) begin
          b.reported_heat = report_t'($urandom_range(0, hi / 2));
          send_tick(b, 1'b0, '0);
        end
      end else if (kind == 7) begin
        // angles at the ends of the range
        repeat ($urandom_range(3, 10)) begin
          if ($urandom_range(0, 1) == 1) wheel = 32'h7FFF_FFFF - $urandom_range(0, 100);
          else wheel = 32'h8000_0000 + $urandom_range(0, 100);
          b.feeder_angle = wheel;
          b.clear_reference = 1'($urandom_range(0, 1));
          b.reported_heat = report_t'($urandom_range(0, 65535));
          send_tick(b, 1'b0, '0);
        end
      end else if (kind == 8) begin
        // unstructured beats
        repeat ($urandom_range(5, 20)) begin
          b.feeder_angle = $urandom();
          b.reported_heat = report_t'($urandom_range(0, 65535));
          b.clear_reference = 1'($urandom_range(0, 1));
          send_tick(b, 1'b0, '0);
        end
      end else begin
        settle_results();
      end
    end
  endtask

  // result-side stall pattern, plus one long hold-off on request
  initial begin
    int unsigned stall_left;
    int unsigned free_left;
    stall_left = 0;
    free_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && free_left == 0) begin
        stall_left = idle_len();
        free_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(1, 12);
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (free_left != 0) free_left--;
      end
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin
    hbfp_pkg::step_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (tick_results_due.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result beat: permit %0b shot %0b heat %0d",
                   out_fire_permitted, out_shot_counted, out_heat_estimate);
        mismatches++;
      end else begin
        want = tick_results_due.pop_front();
        if (out_fire_permitted !== want.fire_permitted ||
            out_shot_counted !== want.shot_counted ||
            out_heat_estimate !== want.heat_estimate) begin
          if (mismatches < 10)
            $display("result mismatch: exp permit %0b shot %0b heat %0d, got %0b %0b %0d",
                     want.fire_permitted, want.shot_counted, want.heat_estimate,
                     out_fire_permitted, out_shot_counted, out_heat_estimate);
          mismatches++;
        end
      end
    end
  end

  // run limit
  initial begin
    #10_000_000;
    $display("tb_top failed");
    $finish;
  end

  // main sequence
  initial begin
    in_valid <= 1'b0;
    in_feeder_angle <= '0;
    in_reported_heat <= '0;
    in_clear_reference <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= hbfp_pkg::CFG_COOL_LIMIT;
    cfg_wdata <= '0;
    rst_n <= 1'b0;

    // defaults after reset: limit 3000, rate 20
    plan.push_back(mk(0, 0, 0, 0, 0, 0, 1, 1, 0, 24'd0));
    plan.push_back(mk(0, 0, 0, 41, 0, 0, 1, 1, 1, 24'd1980));
    plan.push_back(mk(0, 0, 0, 81, 0, 0, 1, 1, 0, 24'd1960));
    plan.push_back(mk(0, 0, 0, 82, 0, 0, 1, 1, 1, 24'd3940));
    plan.push_back(mk(0, 0, 0, 82, 16'hFFFF, 0, 1, 0, 0, 24'd13111000));
    // angle extremes and reference at the top of the range
    plan.push_back(mk(0, 0, 0, 32'h7FFF_FFFF, 0, 1, 0, 0, 0, 0));
    plan.push_back(mk(0, 0, 0, -32'sd5, 0, 0, 0, 0, 0, 0));
    plan.push_back(mk(0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0));
    plan.push_back(mk(0, 0, 0, 32'h8000_0000, 0, 0, 0, 0, 0, 0));
    plan.push_back(mk(0, 0, 0, 32'h8000_0000, 0, 1, 0, 0, 0, 0));
    plan.push_back(mk(0, 0, 0, 40, 0, 1, 0, 0, 0, 0));
    plan.push_back(mk(0, 0, 0, 41, 0, 0, 0, 0, 0, 0));
    // largest limit and rate
    plan.push_back(mk(1, 16'hFFFF, 16'hFFFF, 41, 0, 0, 0, 0, 0, 0));
    plan.push_back(mk(0, 0, 0, 41, 16'hFFFF, 0, 0, 0, 0, 0));
    plan.push_back(mk(0, 0, 0, 200, 16'hFFFF, 0, 0, 0, 0, 0));
    // limit below the margin: never permitted
    plan.push_back(mk(1, 1, 0, 200, 0, 0, 0, 0, 0, 0));
    plan.push_back(mk(0, 0, 0, 300, 1, 1, 0, 0, 0, 0));
    // limit right at the margin, then default limit with rate ignored
    plan.push_back(mk(1, 30, 0, 0, 0, 1, 0, 0, 0, 0));
    plan.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(mk(1, 0, 16'hFFFF, 100, 0, 0, 0, 0, 0, 0));
    plan.push_back(mk(0, 0, 0, 100, 16'hFFFF, 0, 0, 0, 0, 0));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].do_cfg) begin
        settle_results();
        write_regs(plan[i].lim, plan[i].rate);
      end
      send_tick(plan[i].beat, plan[i].typed, plan[i].want);
    end

    // random phases over a spread of register settings
    for (int p = 0; p < 8; p++) begin
      settle_results();
      case (p)
        0: write_regs(16'd0, 16'hFFFF);
        1: write_regs(16'hFFFF, 16'd0);
        2: write_regs(16'hFFFF, 16'hFFFF);
        3: write_regs(16'd1, cfg_word_t'($urandom_range(0, 65535)));
        4: write_regs(16'd30, 16'd0);
        5: write_regs(cfg_word_t'($urandom_range(31, 4000)),
                      cfg_word_t'($urandom_range(0, 400)));
        6: write_regs(16'd3000, 16'd20);
        default: write_regs(cfg_word_t'($urandom_range(0, 65535)),
                            cfg_word_t'($urandom_range(0, 65535)));
      endcase
      if (p == 1) begin
        // long receiver hold-off while the sender keeps pushing
        hold_req = 1'b1;
        eager_left = 200;
      end
      // a phase overruns its count by part of a lag run, about 80 beats on average
      run_phase(120);
    end

    settle_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ----- heat_budget_fire_permit.f -----
hw/rtl/hbfp_pkg.sv
hw/rtl/hbfp_step.sv
hw/rtl/heat_budget_fire_permit.sv
sim/tb_top.sv
